/* sv/pwm_duty_soft_ramp_core_assert.svh */
// Assertion macros shared by the duty ramp RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef PWM_DUTY_SOFT_RAMP_CORE_ASSERT_SVH
`define PWM_DUTY_SOFT_RAMP_CORE_ASSERT_SVH

// same-cycle implication
`define PDSR_ASSERT_HOLD(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PDSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/pdsr_pkg.sv */
`timescale 1ns / 1ps
// Types, constants and helpers for the PWM duty soft-ramp core.
// No dependencies; used by every module of the block.
package pdsr_pkg;

	localparam int DUTY_W   = 8;
	localparam int PERIOD_W = 16;
	localparam int STATUS_W = 3;
	localparam int QUOT_W   = 9;
	localparam int REM_W    = 8;

	localparam logic [STATUS_W-1:0] ST_WORK    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_PROTECT = 3'd4;

	localparam logic [1:0] CFG_PERIOD = 2'd0;
	localparam logic [1:0] CFG_MIN    = 2'd1;
	localparam logic [1:0] CFG_MAX    = 2'd2;

	localparam logic [PERIOD_W-1:0] FULL_SCALE = 16'd200;
	localparam logic [13:0]         DIV25_MUL  = 14'd10486;
	localparam int                  DIV25_SHIFT = 18;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd319;
	localparam logic [DUTY_W-1:0]   MIN_RST    = 8'd20;
	localparam logic [DUTY_W-1:0]   MAX_RST    = 8'd96;
	localparam logic [QUOT_W-1:0]   QUOT_RST   = 9'(319 / 200);
	localparam logic [REM_W-1:0]    REM_RST    = 8'(319 % 200);

	typedef enum logic [1:0] {
		CMP_KEEP,
		CMP_ZERO,
		CMP_PERIOD,
		CMP_SCALE
	} cmp_sel_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		cmp_sel_t          sel;
	} item_t;

	// exact floor(x / 25) for any 13-bit x
	function automatic logic [QUOT_W-1:0] div25(input logic [12:0] x);
		logic [26:0] p;
		p = 27'(x) * 27'(DIV25_MUL);
		return QUOT_W'(p >> DIV25_SHIFT);
	endfunction

endpackage

/* sv/pdsr_step.sv */
`timescale 1ns / 1ps
// Duty step logic: pending tick flags, duty state and compare selection.
// Depends on pdsr_pkg and pwm_duty_soft_ramp_core_assert.svh.
`include "pwm_duty_soft_ramp_core_assert.svh"

module pdsr_step (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic                            load,
	input  logic                            tick_1ms,
	input  logic                            tick_10ms,
	input  logic [pdsr_pkg::STATUS_W-1:0]   status,
	input  logic [pdsr_pkg::DUTY_W-1:0]     target_duty,
	input  logic [pdsr_pkg::DUTY_W-1:0]     min_duty,
	input  logic [pdsr_pkg::DUTY_W-1:0]     max_duty,
	output logic                            valid_s1,
	output pdsr_pkg::item_t                 item_s1
);

	logic [pdsr_pkg::DUTY_W-1:0] duty_q;
	logic                        pend_fast_q;
	logic                        pend_slow_q;

	logic                        pf_c;
	logic                        ps_c;
	logic                        pf_n;
	logic                        ps_n;
	logic [pdsr_pkg::DUTY_W-1:0] duty_n;
	pdsr_pkg::cmp_sel_t          sel_n;

	always_comb begin
		pf_c   = pend_fast_q | tick_1ms;
		ps_c   = pend_slow_q | tick_10ms;
		pf_n   = pf_c;
		ps_n   = ps_c;
		duty_n = duty_q;
		sel_n  = pdsr_pkg::CMP_KEEP;
		if (status == pdsr_pkg::ST_WORK) begin
			if (ps_c) begin
				ps_n = 1'b0;
				if (target_duty >= max_duty) begin
					duty_n = max_duty;
					sel_n  = pdsr_pkg::CMP_PERIOD;
				end else if (duty_q < target_duty) begin
					duty_n = duty_q + 8'd1;
					sel_n  = pdsr_pkg::CMP_SCALE;
				end else if (duty_q > target_duty) begin
					duty_n = duty_q - 8'd1;
					sel_n  = pdsr_pkg::CMP_SCALE;
				end
			end
		end else if (status <= pdsr_pkg::ST_PROTECT) begin
			if (duty_q <= min_duty) begin
				duty_n = '0;
				sel_n  = pdsr_pkg::CMP_ZERO;
			end else if (pf_c) begin
				pf_n   = 1'b0;
				duty_n = duty_q - 8'd1;
				sel_n  = pdsr_pkg::CMP_SCALE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q      <= '0;
			pend_fast_q <= 1'b0;
			pend_slow_q <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			if (accept) begin
				duty_q      <= duty_n;
				pend_fast_q <= pf_n;
				pend_slow_q <= ps_n;
			end
			if (load) begin
				valid_s1 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.duty <= duty_n;
			item_s1.sel  <= sel_n;
		end
	end

	`PDSR_ASSERT_NEXT(a_undef_status_holds, accept && status > pdsr_pkg::ST_PROTECT,
		$stable(duty_q), "duty moved under an undefined status")
	`PDSR_ASSERT_NEXT(a_work_consumes_slow, accept && status == pdsr_pkg::ST_WORK,
		!pend_slow_q, "ramp flag left pending after a work item")

endmodule

/* sv/pdsr_scale.sv */
`timescale 1ns / 1ps
// Compare scaling duty*period/200 in two stages, plus the result register.
// Depends on pdsr_pkg and pwm_duty_soft_ramp_core_assert.svh.
`include "pwm_duty_soft_ramp_core_assert.svh"

module pdsr_scale (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid_s1,
	input  pdsr_pkg::item_t                 item_s1,
	input  logic [pdsr_pkg::PERIOD_W-1:0]   period,
	input  logic [pdsr_pkg::QUOT_W-1:0]     period_quot,
	input  logic [pdsr_pkg::REM_W-1:0]      period_rem,
	input  logic                            out_ready,
	output logic                            take_s1,
	output logic                            out_valid,
	output logic [pdsr_pkg::PERIOD_W-1:0]   compare_value,
	output logic [pdsr_pkg::DUTY_W-1:0]     duty_now
);

	logic                          valid_s2;
	logic [pdsr_pkg::DUTY_W-1:0]   duty_s2;
	pdsr_pkg::cmp_sel_t            sel_s2;
	logic [16:0]                   hi_s2;
	logic [15:0]                   lo_s2;

	logic                          out_valid_q;
	logic [pdsr_pkg::PERIOD_W-1:0] compare_q;
	logic [pdsr_pkg::DUTY_W-1:0]   duty_out_q;

	logic                          take_s2;
	logic [pdsr_pkg::QUOT_W-1:0]   lo_quot;
	logic [17:0]                   sum;
	logic [pdsr_pkg::PERIOD_W-1:0] scaled;

	assign take_s2 = !out_valid_q || out_ready;
	assign take_s1 = !valid_s2 || take_s2;

	// duty*period/200 = duty*quot + floor(duty*rem/200)
	always_comb begin
		lo_quot = pdsr_pkg::div25(lo_s2[15:3]);
		sum     = 18'(hi_s2) + 18'(lo_quot);
		scaled  = (sum > 18'h0FFFF) ? '1 : sum[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			compare_q   <= '0;
		end else begin
			if (take_s1) begin
				valid_s2 <= valid_s1;
			end
			if (take_s2) begin
				out_valid_q <= valid_s2;
				if (valid_s2) begin
					unique case (sel_s2)
						pdsr_pkg::CMP_KEEP:   compare_q <= compare_q;
						pdsr_pkg::CMP_ZERO:   compare_q <= '0;
						pdsr_pkg::CMP_PERIOD: compare_q <= period;
						pdsr_pkg::CMP_SCALE:  compare_q <= scaled;
						default:              compare_q <= compare_q;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && valid_s1) begin
			duty_s2 <= item_s1.duty;
			sel_s2  <= item_s1.sel;
			hi_s2   <= 17'(item_s1.duty) * 17'(period_quot);
			lo_s2   <= 16'(item_s1.duty) * 16'(period_rem);
		end
		if (take_s2 && valid_s2) begin
			duty_out_q <= duty_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign compare_value = compare_q;
	assign duty_now      = duty_out_q;

	`PDSR_ASSERT_NEXT(a_zero_duty_zero_compare,
		take_s2 && valid_s2 && sel_s2 == pdsr_pkg::CMP_SCALE && duty_s2 == 8'd0,
		compare_q == 16'd0, "nonzero compare for zero duty")

endmodule

/* sv/pwm_duty_soft_ramp_core.sv */
`timescale 1ns / 1ps
// Top level of the PWM duty soft-ramp core: stream ports, registers, stage control.
// Depends on pdsr_pkg, pdsr_step, pdsr_scale and pwm_duty_soft_ramp_core_assert.svh.
`include "pwm_duty_soft_ramp_core_assert.svh"

// Takes one item per clock cycle unless the output stalls with the stages full, and
// returns exactly one result per item, in order, through the item register, the
// stage-2 register and the output register. The duty state is updated in the cycle the item is taken,
// so items may follow back to back; the compare value is then scaled in two
// registered stages, a multiply by the period split into quotient and remainder of
// 200, then a reciprocal divide by 200. The period split is computed when the period
// register is written. Results wait in an output register, and input is still taken
// while it holds one, as long as the stages before it have room.
module pwm_duty_soft_ramp_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // tick_1ms, tick_10ms, status[2:0], target_duty[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // compare_value[15:0], duty_now[7:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [pdsr_pkg::PERIOD_W-1:0] period_q;
	logic [pdsr_pkg::DUTY_W-1:0]   min_duty_q;
	logic [pdsr_pkg::DUTY_W-1:0]   max_duty_q;
	logic [pdsr_pkg::QUOT_W-1:0]   quot_q;
	logic [pdsr_pkg::REM_W-1:0]    rem_q;

	logic [pdsr_pkg::QUOT_W-1:0]   cfg_quot;
	logic [pdsr_pkg::PERIOD_W-1:0] cfg_rem;

	logic                          accept;
	logic                          take_s1;
	logic                          valid_s1;
	pdsr_pkg::item_t               item_s1;
	logic [pdsr_pkg::PERIOD_W-1:0] compare_value;
	logic [pdsr_pkg::DUTY_W-1:0]   duty_now;

	assign cfg_ready = 1'b1;

	always_comb begin
		cfg_quot = pdsr_pkg::div25(cfg_data[15:3]);
		cfg_rem  = cfg_data - 16'(cfg_quot) * pdsr_pkg::FULL_SCALE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= pdsr_pkg::PERIOD_RST;
			min_duty_q <= pdsr_pkg::MIN_RST;
			max_duty_q <= pdsr_pkg::MAX_RST;
			quot_q     <= pdsr_pkg::QUOT_RST;
			rem_q      <= pdsr_pkg::REM_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pdsr_pkg::CFG_PERIOD: begin
					period_q <= cfg_data;
					quot_q   <= cfg_quot;
					rem_q    <= cfg_rem[7:0];
				end
				pdsr_pkg::CFG_MIN: min_duty_q <= cfg_data[7:0];
				pdsr_pkg::CFG_MAX: max_duty_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !valid_s1 || take_s1;
	assign accept   = s_tvalid && s_tready;

	pdsr_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.load        (s_tready),
		.tick_1ms    (s_tdata[0]),
		.tick_10ms   (s_tdata[1]),
		.status      (s_tdata[4:2]),
		.target_duty (s_tdata[12:5]),
		.min_duty    (min_duty_q),
		.max_duty    (max_duty_q),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1)
	);

	pdsr_scale u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.period        (period_q),
		.period_quot   (quot_q),
		.period_rem    (rem_q),
		.out_ready     (m_tready),
		.take_s1       (take_s1),
		.out_valid     (m_tvalid),
		.compare_value (compare_value),
		.duty_now      (duty_now)
	);

	assign m_tdata = {duty_now, compare_value};

	`PDSR_ASSERT_HOLD(a_ready_when_out_empty, !m_tvalid, s_tready,
		"input stalled while the result register is empty")

endmodule
